@@ rtl/lcr_pkg.sv @@
package lcr_pkg;

  localparam int LINE_MAX = 64;
  localparam int LEN_W = $clog2(LINE_MAX);

  localparam int PREFIX_LEN = 4;
  localparam int WORD_COUNT = 3;
  localparam int WORD_MAX = 5;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_TOUCH = 2'd1;
  localparam logic [1:0] CODE_FEED  = 2'd2;
  localparam logic [1:0] CODE_SLEEP = 2'd3;

  localparam logic [PREFIX_LEN-1:0][7:0] PREFIX_CHARS = {",", "D", "M", "C"};

  // Word characters, first character in the lowest entry; unused entries are zero.
  localparam logic [WORD_COUNT-1:0][WORD_MAX-1:0][7:0] WORD_CHARS = {
    {"P", "E", "E", "L", "S"},
    {8'h00, "D", "E", "E", "F"},
    {"H", "C", "U", "O", "T"}
  };

  localparam logic [WORD_COUNT-1:0][2:0] WORD_LEN = {3'd5, 3'd4, 3'd5};

  localparam logic [WORD_COUNT-1:0][1:0] WORD_CMD = {CODE_SLEEP, CODE_FEED, CODE_TOUCH};

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic       load;
    logic [1:0] command;
  } line_result_t;

endpackage

@@ rtl/lcr_in_reg.sv @@
module lcr_in_reg
  import lcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       take,
  output byte_item_t item
);

  logic       valid;
  logic [7:0] data;

  assign s_tready = !valid || take;
  assign item = '{valid: valid, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_tdata;
    end
  end

endmodule

@@ rtl/lcr_matcher.sv @@
module lcr_matcher
  import lcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  byte_item_t   item,
  input  logic         out_free,
  output logic         take,
  output line_result_t result
);

  logic [LEN_W-1:0]      line_length;
  logic [LEN_W-1:0]      line_length_next;
  logic [WORD_COUNT-1:0] match_alive;
  logic [WORD_COUNT-1:0] match_alive_next;
  logic                  is_cr;
  logic                  is_lf;
  logic [LEN_W-1:0]      word_pos;
  logic [1:0]            end_cmd;

  assign is_cr = (item.data == CH_CR);
  assign is_lf = (item.data == CH_LF);

  // A newline needs room in the result register; other bytes never wait.
  assign take = item.valid && (!is_lf || out_free);

  assign result.load = take && is_lf;
  assign result.command = end_cmd;

  assign word_pos = line_length - LEN_W'(PREFIX_LEN);

  always_comb begin
    end_cmd = CODE_NONE;
    for (int k = 0; k < WORD_COUNT; k++) begin
      if (match_alive[k] && line_length == LEN_W'(PREFIX_LEN) + LEN_W'(WORD_LEN[k])) begin
        end_cmd = WORD_CMD[k];
      end
    end
  end

  always_comb begin
    line_length_next = line_length;
    match_alive_next = match_alive;
    if (is_lf) begin
      line_length_next = '0;
      match_alive_next = '1;
    end else if (!is_cr && line_length < LEN_W'(LINE_MAX - 1)) begin
      line_length_next = line_length + 1'b1;
      for (int k = 0; k < WORD_COUNT; k++) begin
        if (line_length < LEN_W'(PREFIX_LEN)) begin
          if (item.data != PREFIX_CHARS[line_length[1:0]]) begin
            match_alive_next[k] = 1'b0;
          end
        end else if (word_pos >= LEN_W'(WORD_LEN[k])) begin
          match_alive_next[k] = 1'b0;
        end else if (item.data != WORD_CHARS[k][word_pos[2:0]]) begin
          match_alive_next[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      match_alive <= '1;
    end else if (take) begin
      line_length <= line_length_next;
      match_alive <= match_alive_next;
    end
  end

endmodule

@@ rtl/lcr_out_reg.sv @@
module lcr_out_reg
  import lcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  line_result_t result,
  output logic         out_free,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata
);

  logic       valid;
  logic [1:0] command;

  assign out_free = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tdata = {6'b0, command};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= result.load;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      command <= result.command;
    end
  end

endmodule

@@ rtl/line_command_recognizer.sv @@
// Line command recognizer.
// Received serial bytes enter on the s_ stream channel, one byte per transfer.
// Carriage returns are ignored; any other byte except newline is a character
// of the current line. A newline ends the line and produces one transfer on
// the m_ channel carrying the command: 0 none, 1 TOUCH, 2 FEED, 3 SLEEP, for
// the exact lines "CMD,TOUCH", "CMD,FEED" and "CMD,SLEEP".
// A newline held in the input register moves into the result register, which
// drives m_tvalid, once the result register is empty or m_tready is high.
// The block takes one byte per cycle while no newline waits for the result
// register; the match update between the two registers is combinational.
// When the receiver holds m_tready low, the result stays registered; further
// ordinary characters still flow, and the next newline waits in the input
// register, which then stops s_tready until the result is taken.
// Reset (rst, synchronous) empties both registers and starts a fresh line.
module line_command_recognizer
  import lcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] command, [7:2] zero
);

  byte_item_t   item;
  line_result_t result;
  logic         take;
  logic         out_free;

  lcr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  lcr_matcher u_matcher (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .result   (result)
  );

  lcr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb
  import lcr_pkg::*;
();

  localparam int STIM_BYTES = 1650;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_WORDS = 3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [1:0] command, [7:2] zero

  line_command_recognizer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  string      cmd_prefix = "CMD,";
  string      cmd_words [NUM_WORDS] = '{"TOUCH", "FEED", "SLEEP"};
  logic [1:0] word_code [NUM_WORDS] = '{CODE_TOUCH, CODE_FEED, CODE_SLEEP};

  // Line tracker state: stored character count and one live flag per word.
  logic [LEN_W-1:0] cur_len = '0;
  logic [2:0]       word_alive = '1;

  logic [7:0]  pending_bytes [$];
  logic [1:0]  cmd_expected [$];
  int          total_bytes = 0;
  int          accepted_bytes = 0;
  int          mismatch_count = 0;
  int          cr_pct = 0;
  int          send_gap = 0;
  bit          send_fast = 1'b0;
  int          recv_wait = 0;
  bit          recv_fast = 1'b0;
  int          hold_left = 0;
  int          holds_done = 0;
  int unsigned cycle_count = 0;

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  // Updates the line tracker with one accepted byte; a newline queues its command.
  task automatic take_rx_byte(input logic [7:0] ch);
    logic [1:0] code;
    int w;
    code = CODE_NONE;
    if (ch == CH_LF) begin
      for (int k = 0; k < NUM_WORDS; k++)
        if (word_alive[k] && cur_len == cmd_prefix.len() + cmd_words[k].len())
          code = word_code[k];
      cmd_expected.push_back(code);
      cur_len = '0;
      word_alive = '1;
    end else if (ch != CH_CR && cur_len < LINE_MAX - 1) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        if (cur_len < cmd_prefix.len()) begin
          if (ch != cmd_prefix[cur_len]) word_alive[k] = 1'b0;
        end else begin
          w = cur_len - cmd_prefix.len();
          if (w >= cmd_words[k].len() || ch != cmd_words[k][w]) word_alive[k] = 1'b0;
        end
      end
      cur_len = cur_len + 1'b1;
    end
  endtask

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  task automatic add_char(input logic [7:0] ch);
    if ($urandom_range(0, 99) < cr_pct) pending_bytes.push_back(CH_CR);
    pending_bytes.push_back(ch);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  initial begin
    string      word;
    string      full;
    int         kind;
    int         pos;
    int         n;
    logic [7:0] other;

    add_text("CMD,TOUCH");
    add_char(CH_CR);
    add_char(CH_LF);
    add_text("CMD,FEED");
    add_char(CH_LF);
    add_text("CMD,SLEEP");
    add_char(CH_LF);
    add_char(CH_LF);
    add_char(8'h00);
    add_char(8'hFF);
    add_char(CH_LF);

    // A random mix of well-formed command lines (the largest share), near misses, long lines, empty lines and noise.
    while (pending_bytes.size() < STIM_BYTES) begin
      cr_pct = ($urandom_range(0, 3) == 0) ? 15 : 0;
      word = cmd_words[$urandom_range(0, NUM_WORDS - 1)];
      full = {cmd_prefix, word};
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        add_text(full);
      end else if (kind < 66) begin
        case ($urandom_range(0, 3))
          0: add_text(full.substr(0, $urandom_range(0, full.len() - 2)));
          1: begin
            pos = $urandom_range(0, full.len() - 1);
            other = ($urandom_range(0, 1) == 1) ? any_char()
                                                : 8'($urandom_range(8'h41, 8'h5A));
            if (other == full[pos]) other = other ^ 8'h20;
            for (int i = 0; i < full.len(); i++) add_char(i == pos ? other : full[i]);
          end
          2: begin
            add_text(full);
            add_char(any_char());
          end
          default: begin
            add_text(cmd_prefix);
            n = $urandom_range(3, 6);
            for (int i = 0; i < n; i++) begin
              word = cmd_words[$urandom_range(0, NUM_WORDS - 1)];
              add_char(i < word.len() ? word[i] : word[word.len() - 1]);
            end
          end
        endcase
      end else if (kind < 72) begin
        case ($urandom_range(0, 3))
          0: n = LINE_MAX - 2;
          1: n = LINE_MAX - 1;
          2: n = LINE_MAX;
          default: n = LINE_MAX + 6;
        endcase
        pos = 0;
        if ($urandom_range(0, 1) == 1) begin
          add_text(full);
          pos = full.len();
        end
        for (int i = pos; i < n; i++) add_char(any_char());
      end else if (kind < 82) begin
        // Empty line.
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
      end
      add_char(CH_LF);
    end
    total_bytes = pending_bytes.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (accepted_bytes < total_bytes) @(posedge clk);
    while (cmd_expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Sender: one byte per transfer, with a random gap drawn per byte except in fast mode or during a receiver hold.
  always @(posedge clk) begin
    logic fire;
    fire = s_tvalid && s_tready;
    if (fire) begin
      take_rx_byte(s_tdata);
      accepted_bytes <= accepted_bytes + 1;
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || fire) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_tdata <= pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 149) == 0) send_fast = !send_fast;
        send_gap = (send_fast || hold_left > 0) ? 0 : $urandom_range(0, 13);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Twice during the run the receiver stops for a long stretch so that results back up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && accepted_bytes >= 500 * (holds_done + 1)) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Receiver: checks each result transfer against the oldest queued command.
  always @(posedge clk) begin
    logic [1:0] want;
    if (m_tvalid && m_tready) begin
      if (cmd_expected.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, tdata %02h", m_tdata));
      end else begin
        want = cmd_expected.pop_front();
        if (m_tdata[1:0] !== want)
          flag_mismatch($sformatf("command %0d, expected %0d", m_tdata[1:0], want));
        if (m_tdata[7:2] !== 6'd0)
          flag_mismatch($sformatf("padding bits %b, expected zero", m_tdata[7:2]));
      end
      if ($urandom_range(0, 29) == 0) recv_fast = !recv_fast;
      recv_wait = recv_fast ? 0 : $urandom_range(0, 13);
    end
    if (rst || hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

@@ sim.f @@
rtl/lcr_pkg.sv
rtl/lcr_in_reg.sv
rtl/lcr_matcher.sv
rtl/lcr_out_reg.sv
rtl/line_command_recognizer.sv
dv/tb.sv
